[sv/prefix_code_bit_decoder_macros.svh]
// Assertion macros used by the checker file of the prefix code decoder.
`ifndef PREFIX_CODE_BIT_DECODER_MACROS_SVH
`define PREFIX_CODE_BIT_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PCBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prefix_code_bit_decoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PCBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prefix_code_bit_decoder: next-cycle check failed");

`endif

[sv/pcbd_pkg.sv]
`default_nettype none

package pcbd_pkg;

    localparam int TABLE_ENTRIES   = 32;
    localparam int MAX_CODE_LENGTH = 16;
    localparam int SYMBOL_BITS     = 8;

    // Fixed field widths of the stream items.
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int CODE_W  = 16;
    localparam int ELEN_W  = 5;
    localparam int ESYM_W  = 8;
    localparam int KIND_W  = 2;
    localparam int OSYM_W  = 8;
    localparam int DROP_W  = 5;

    // Input tdata layout, lowest bit first.
    localparam int SLOT_LSB = 0;
    localparam int CODE_LSB = SLOT_LSB + SLOT_W;
    localparam int ELEN_LSB = CODE_LSB + CODE_W;
    localparam int ESYM_LSB = ELEN_LSB + ELEN_W;
    localparam int BIT_LSB  = ESYM_LSB + ESYM_W;
    localparam int S_RAW_W  = BIT_LSB + 1;
    localparam int S_TDATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W;

    // Output tdata layout, lowest bit first.
    localparam int OSYM_LSB  = 0;
    localparam int DROP_LSB  = OSYM_LSB + OSYM_W;
    localparam int M_RAW_W   = DROP_LSB + DROP_W;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;
    localparam int M_TUSER_W = KIND_W;

    // Internal widths that follow from the constants above.
    localparam int PEND_W = MAX_CODE_LENGTH;
    localparam int LEN_W  = $clog2(MAX_CODE_LENGTH + 1);
    localparam int CMP_W  = (PEND_W > CODE_W) ? PEND_W : CODE_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_BIT  = 2'd1,
        OP_END  = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL   = 2'd0,
        KIND_END      = 2'd1,
        KIND_OVERLONG = 2'd2
    } t_kind;

endpackage

`default_nettype wire

[sv/prefix_code_bit_decoder.sv]
// An accepted input item is held in the input register; its result is then registered in the result register.
// Throughput: one input item per cycle while the output does not stall; every table entry has its own comparator.
// The input side stalls only while a result item waits and the output is not taken.
// Reset (i_rst_n low, synchronous) marks every table entry invalid, clears the
// pending code and its length, and empties the input and result registers.
`default_nettype none

module prefix_code_bit_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // entry_slot, entry_code, entry_length, entry_symbol, code_bit, zero fill
    input  logic [pcbd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // operation
    input  logic [pcbd_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // symbol, dropped_bits, zero fill
    output logic [pcbd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // result_kind
    output logic [pcbd_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import pcbd_pkg::*;

    // Input register.
    logic                r_in_valid;
    t_op                 r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [CODE_W-1:0]   r_code;
    logic [ELEN_W-1:0]   r_elen;
    logic [ESYM_W-1:0]   r_esym;
    logic                r_bit;

    // Code table and pending code.
    logic [CODE_W-1:0]      r_tbl_code [TABLE_ENTRIES];
    logic [ELEN_W-1:0]      r_tbl_len  [TABLE_ENTRIES];
    logic [SYMBOL_BITS-1:0] r_tbl_sym  [TABLE_ENTRIES];
    logic [PEND_W-1:0]      r_pend_code;
    logic [LEN_W-1:0]       r_pend_len;

    // Result register.
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [OSYM_W-1:0]   r_out_sym;
    logic [DROP_W-1:0]   r_out_drop;

    logic                   advance;
    logic [PEND_W-1:0]      shift_code;
    logic [LEN_W-1:0]       shift_len;
    logic [CMP_W-1:0]       cmp_mask;
    logic [TABLE_ENTRIES-1:0] hit;
    logic                   any_hit;
    logic [SYMBOL_BITS-1:0] hit_sym;
    logic                   res_valid;
    t_kind                  res_kind;
    logic [OSYM_W-1:0]      res_sym;
    logic [DROP_W-1:0]      res_drop;
    logic [PEND_W-1:0]      n_pend_code;
    logic [LEN_W-1:0]       n_pend_len;
    logic                   n_out_valid;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    assign shift_code = PEND_W'({r_pend_code, r_bit});
    assign shift_len  = r_pend_len + LEN_W'(1);
    assign cmp_mask   = ~({CMP_W{1'b1}} << shift_len);

    // One comparator per table entry; the pending code never has bits above its length.
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit[i] = (r_tbl_len[i] != '0)
                  && (32'(r_tbl_len[i]) == 32'(shift_len))
                  && ((CMP_W'(r_tbl_code[i]) & cmp_mask) == CMP_W'(shift_code));
        end
    end

    // Lowest matching slot wins.
    always_comb begin
        any_hit = 1'b0;
        hit_sym = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                any_hit = 1'b1;
                hit_sym = r_tbl_sym[i];
            end
        end
    end

    always_comb begin
        res_valid   = 1'b0;
        res_kind    = KIND_SYMBOL;
        res_sym     = '0;
        res_drop    = '0;
        n_pend_code = r_pend_code;
        n_pend_len  = r_pend_len;
        case (r_op)
            OP_BIT: begin
                n_pend_code = shift_code;
                n_pend_len  = shift_len;
                if (any_hit) begin
                    res_valid   = 1'b1;
                    res_sym     = OSYM_W'(hit_sym);
                    n_pend_code = '0;
                    n_pend_len  = '0;
                end else if (32'(shift_len) >= 32'(MAX_CODE_LENGTH)) begin
                    res_valid   = 1'b1;
                    res_kind    = KIND_OVERLONG;
                    res_drop    = DROP_W'(shift_len);
                    n_pend_code = '0;
                    n_pend_len  = '0;
                end
            end
            OP_END: begin
                res_valid   = 1'b1;
                res_kind    = KIND_END;
                res_drop    = DROP_W'(r_pend_len);
                n_pend_code = '0;
                n_pend_len  = '0;
            end
            default: begin
                // Loads and the unused operation leave the pending code alone.
            end
        endcase
    end

    assign n_out_valid = advance ? res_valid : (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend_code <= '0;
            r_pend_len  <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_tbl_len[i] <= '0;
            end
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_pend_code <= n_pend_code;
                r_pend_len  <= n_pend_len;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (advance && r_op == OP_LOAD && 32'(r_slot) == i) begin
                    r_tbl_len[i] <= r_elen;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_op   <= t_op'(i_s_tuser);
            r_slot <= i_s_tdata[SLOT_LSB +: SLOT_W];
            r_code <= i_s_tdata[CODE_LSB +: CODE_W];
            r_elen <= i_s_tdata[ELEN_LSB +: ELEN_W];
            r_esym <= i_s_tdata[ESYM_LSB +: ESYM_W];
            r_bit  <= i_s_tdata[BIT_LSB];
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (advance && r_op == OP_LOAD && 32'(r_slot) == i) begin
                r_tbl_code[i] <= r_code;
                r_tbl_sym[i]  <= SYMBOL_BITS'(r_esym);
            end
        end
        if (advance && res_valid) begin
            r_out_kind <= res_kind;
            r_out_sym  <= res_sym;
            r_out_drop <= res_drop;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = M_TDATA_W'({r_out_drop, r_out_sym});

endmodule

`default_nettype wire

[sv/pcbd_checker.sv]
`default_nettype none
`include "prefix_code_bit_decoder_macros.svh"

module pcbd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [pcbd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input logic [pcbd_pkg::S_TUSER_W-1:0]  i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [pcbd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic [pcbd_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import pcbd_pkg::*;

    logic [OSYM_W-1:0] out_sym;
    logic [DROP_W-1:0] out_drop;

    assign out_sym  = o_m_tdata[OSYM_LSB +: OSYM_W];
    assign out_drop = o_m_tdata[DROP_LSB +: DROP_W];

    // No result item may appear straight out of reset.
    `PCBD_ASSERT_IMP(a_no_result_after_reset, $past(!i_rst_n), !o_m_tvalid)

    // A result item that is not taken holds its value.
    `PCBD_ASSERT_NXT(a_result_holds, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // With the result register empty the input side never stalls.
    `PCBD_ASSERT_IMP(a_ready_when_empty, !o_m_tvalid, o_s_tready)

    // A symbol result drops nothing; the other kinds carry no symbol.
    `PCBD_ASSERT_IMP(a_fields_by_kind, o_m_tvalid,
        (o_m_tuser == KIND_SYMBOL && out_drop == '0) ||
        (o_m_tuser != KIND_SYMBOL && out_sym == '0))

    // An overlong code always drops a full maximum-length code.
    `PCBD_ASSERT_IMP(a_overlong_drop, o_m_tvalid && o_m_tuser == KIND_OVERLONG,
        out_drop == DROP_W'(MAX_CODE_LENGTH))

endmodule

bind prefix_code_bit_decoder pcbd_checker u_pcbd_checker (.*);

`default_nettype wire
